### rtl/core/tled_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twin Lorenz divergence package
// Shared widths, register indexes and the request and result payload types.
// ----------------------------------------------------------------------------
package tled_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 20;
    localparam int STEP_BITS     = 16;
    localparam int PARAM_BITS    = WORD_BITS - 1;
    localparam int DT_BITS       = FRACTION_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA_A   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RHO_A     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BETA_A    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA_B   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RHO_B     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_BETA_B    = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE = 3'd6;

    localparam logic [PARAM_BITS-1:0] SIGMA_RESET = PARAM_BITS'(10485760);
    localparam logic [PARAM_BITS-1:0] RHO_RESET   = PARAM_BITS'(29360128);
    localparam logic [PARAM_BITS-1:0] BETA_RESET  = PARAM_BITS'(2796203);
    localparam logic [DT_BITS-1:0]    DT_RESET    = DT_BITS'(10486);

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic signed [WORD_BITS-1:0] start_x_a;
        logic signed [WORD_BITS-1:0] start_y_a;
        logic signed [WORD_BITS-1:0] start_z_a;
        logic signed [WORD_BITS-1:0] start_x_b;
        logic signed [WORD_BITS-1:0] start_y_b;
        logic signed [WORD_BITS-1:0] start_z_b;
    } req_t;

    typedef struct packed {
        logic [STEP_BITS-1:0]        step_index;
        logic signed [WORD_BITS-1:0] pos_x_a;
        logic signed [WORD_BITS-1:0] pos_y_a;
        logic signed [WORD_BITS-1:0] pos_z_a;
        logic signed [WORD_BITS-1:0] pos_x_b;
        logic signed [WORD_BITS-1:0] pos_y_b;
        logic signed [WORD_BITS-1:0] pos_z_b;
        logic [PARAM_BITS-1:0]       separation;
        logic [PARAM_BITS-1:0]       peak_separation;
        logic [STEP_BITS-1:0]        peak_step;
        logic                        overflowed;
    } res_t;

endpackage

### rtl/core/tled_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-and-add over one multiplier bit per cycle, two's complement operands.
// ----------------------------------------------------------------------------
module tled_mul #(
    parameter int WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [WIDTH-1:0]   op_a,
    input  logic signed [WIDTH-1:0]   op_b,
    output logic                      done,
    output logic signed [2*WIDTH-1:0] product
);
    localparam int CW = $clog2(WIDTH);

    logic [2*WIDTH-1:0] mcand_reg, mcand_next;
    logic [WIDTH-1:0]   mplier_reg, mplier_next;
    logic [2*WIDTH-1:0] acc_reg, acc_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [2*WIDTH-1:0] addend;
    logic               last;

    assign last   = (cnt_reg == CW'(WIDTH - 1));
    assign addend = mplier_reg[0] ? mcand_reg : '0;

    always_comb begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start) begin
            mcand_next  = {{WIDTH{op_a[WIDTH-1]}}, op_a};
            mplier_next = op_b;
            acc_next    = '0;
            cnt_next    = '0;
            run_next    = 1'b1;
        end else if (run_reg) begin
            // The sign bit of the multiplier weighs negative.
            acc_next    = last ? acc_reg - addend : acc_reg + addend;
            mcand_next  = {mcand_reg[2*WIDTH-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[WIDTH-1:1]};
            cnt_next    = cnt_reg + CW'(1);
            if (last) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done    = done_reg;
    assign product = $signed(acc_reg);

endmodule

### rtl/core/tled_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit-serial integer square root
// Produces one root bit per cycle from a radicand of twice the root width.
// ----------------------------------------------------------------------------
module tled_sqrt #(
    parameter int WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [2*WIDTH-1:0]   radicand,
    output logic                 done,
    output logic [WIDTH-1:0]     root
);
    localparam int CW = $clog2(WIDTH);

    logic [2*WIDTH-1:0] rad_reg, rad_next;
    logic [WIDTH+1:0]   rem_reg, rem_next;
    logic [WIDTH-1:0]   root_reg, root_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [WIDTH+3:0]   rem_sh;
    logic [WIDTH+3:0]   trial;
    logic               fits;

    assign rem_sh = {rem_reg, rad_reg[2*WIDTH-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            rem_next  = fits ? (WIDTH+2)'(rem_sh - trial) : (WIDTH+2)'(rem_sh);
            root_next = {root_reg[WIDTH-2:0], fits};
            rad_next  = {rad_reg[2*WIDTH-3:0], 2'b00};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/core/twin_lorenz_euler_divergence.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Twin Lorenz Euler integrator with divergence tracking
// Two Lorenz trajectories stepped by forward Euler, with distance and peak.
// ----------------------------------------------------------------------------
// A request of kind start loads both points, clears the step count and the
// overflow flag and sets the peak to the starting distance; a request of kind
// step advances both points by one Euler step. Every request yields exactly
// one result. All products run on one bit-serial multiplier and the distance
// on one digit-serial square root. A step request performs fourteen products
// plus three squares; a start request performs three squares. An overflowing
// coordinate difference ends the distance early and shortens a request.
// One request is processed at a time, but a new request is taken as soon as
// the previous result has moved into the output register.
// ----------------------------------------------------------------------------
module twin_lorenz_euler_divergence (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tled_pkg::req_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tled_pkg::res_t                      m_data,
    input  logic                                cfg_wr_en,
    input  logic [tled_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tled_pkg::PARAM_BITS-1:0]     cfg_wr_data
);
    import tled_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int PW = PARAM_BITS;

    localparam logic signed [2*W-1:0] WMAX2 = (2*W)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [2*W-1:0] WMIN2 = -WMAX2 - (2*W)'(1);

    // Micro-operation sequence; each issues one product on the shared multiplier.
    localparam logic [3:0] OP_DX  = 4'd0;
    localparam logic [3:0] OP_DY  = 4'd1;
    localparam logic [3:0] OP_PXY = 4'd2;
    localparam logic [3:0] OP_DZ  = 4'd3;
    localparam logic [3:0] OP_NX  = 4'd4;
    localparam logic [3:0] OP_NY  = 4'd5;
    localparam logic [3:0] OP_NZ  = 4'd6;
    localparam logic [3:0] OP_SQX = 4'd7;
    localparam logic [3:0] OP_SQY = 4'd8;
    localparam logic [3:0] OP_SQZ = 4'd9;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_MULW  = 5'b00100,
        ST_SQRTW = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    function automatic logic signed [2*W-1:0] ext(input logic signed [W-1:0] v);
        return {{W{v[W-1]}}, v};
    endfunction

    function automatic logic signed [W-1:0] sat_w(input logic signed [2*W-1:0] v);
        logic signed [W-1:0] r;
        if (v > WMAX2) begin
            r = WMAX2[W-1:0];
        end else if (v < WMIN2) begin
            r = WMIN2[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic ovf_w(input logic signed [2*W-1:0] v);
        return (v > WMAX2) || (v < WMIN2);
    endfunction

    // Configuration registers.
    logic [PW-1:0]      sigma_a_reg, rho_a_reg, beta_a_reg;
    logic [PW-1:0]      sigma_b_reg, rho_b_reg, beta_b_reg;
    logic [DT_BITS-1:0] dt_reg;

    // Sequencer and datapath state.
    state_t                 state_reg, state_next;
    logic [3:0]             op_reg, op_next;
    logic                   tsel_reg, tsel_next;
    logic                   kind_reg, kind_next;
    logic signed [W-1:0]    pa_reg [3];
    logic signed [W-1:0]    pb_reg [3];
    logic signed [W-1:0]    pa_next [3];
    logic signed [W-1:0]    pb_next [3];
    logic signed [W-1:0]    d_reg [3];
    logic signed [W-1:0]    d_next [3];
    logic signed [W-1:0]    tmp_reg, tmp_next;
    logic [2*W-1:0]         sum_reg, sum_next;
    logic [PW-1:0]          sep_reg, sep_next;
    logic [STEP_BITS-1:0]   cnt_reg, cnt_next;
    logic [PW-1:0]          peak_reg, peak_next;
    logic [STEP_BITS-1:0]   peak_pos_reg, peak_pos_next;
    logic                   flag_reg, flag_next;
    logic                   m_valid_reg;
    res_t                   m_data_reg;

    // Shared arithmetic.
    logic                   mul_start, mul_done;
    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [2*W-1:0]  mul_p;
    logic                   sqrt_start, sqrt_done;
    logic [W-1:0]           sqrt_root;

    logic signed [W-1:0]    cx, cy, cz;
    logic [PW-1:0]          c_sigma, c_rho, c_beta;
    logic signed [W-1:0]    dt_eff;
    logic signed [2*W-1:0]  pre_sum;
    logic signed [2*W-1:0]  diff2;
    logic                   diff_bad;
    logic signed [2*W-1:0]  q_wide;
    logic signed [W-1:0]    q;
    logic                   q_ovf;
    logic signed [2*W-1:0]  post_sum;
    logic                   root_big;
    logic                   out_free;

    assign cx      = tsel_reg ? pb_reg[0] : pa_reg[0];
    assign cy      = tsel_reg ? pb_reg[1] : pa_reg[1];
    assign cz      = tsel_reg ? pb_reg[2] : pa_reg[2];
    assign c_sigma = tsel_reg ? sigma_b_reg : sigma_a_reg;
    assign c_rho   = tsel_reg ? rho_b_reg : rho_a_reg;
    assign c_beta  = tsel_reg ? beta_b_reg : beta_a_reg;

    // A step above 1.0 is taken as 1.0.
    assign dt_eff = (dt_reg > DT_BITS'(1 << F)) ? W'(1 << F) : W'(dt_reg);

    assign q_wide   = mul_p >>> F;
    assign q        = sat_w(q_wide);
    assign q_ovf    = ovf_w(q_wide);
    assign root_big = sqrt_root[W-1];
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_a_reg <= SIGMA_RESET;
            rho_a_reg   <= RHO_RESET;
            beta_a_reg  <= BETA_RESET;
            sigma_b_reg <= SIGMA_RESET;
            rho_b_reg   <= RHO_RESET;
            beta_b_reg  <= BETA_RESET;
            dt_reg      <= DT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SIGMA_A:   sigma_a_reg <= cfg_wr_data;
                REG_RHO_A:     rho_a_reg   <= cfg_wr_data;
                REG_BETA_A:    beta_a_reg  <= cfg_wr_data;
                REG_SIGMA_B:   sigma_b_reg <= cfg_wr_data;
                REG_RHO_B:     rho_b_reg   <= cfg_wr_data;
                REG_BETA_B:    beta_b_reg  <= cfg_wr_data;
                REG_STEP_SIZE: dt_reg      <= cfg_wr_data[DT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Operand selection for the product issued by the current micro-op.
    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        pre_sum  = '0;
        diff2    = '0;
        case (op_reg)
            OP_DX: begin
                pre_sum = ext(cy) - ext(cx);
                mul_a   = $signed({1'b0, c_sigma});
                mul_b   = sat_w(pre_sum);
            end
            OP_DY: begin
                pre_sum = $signed({{(W+1){1'b0}}, c_rho}) - ext(cz);
                mul_a   = cx;
                mul_b   = sat_w(pre_sum);
            end
            OP_PXY: begin
                mul_a = cx;
                mul_b = cy;
            end
            OP_DZ: begin
                mul_a = $signed({1'b0, c_beta});
                mul_b = cz;
            end
            OP_NX: begin
                mul_a = d_reg[0];
                mul_b = dt_eff;
            end
            OP_NY: begin
                mul_a = d_reg[1];
                mul_b = dt_eff;
            end
            OP_NZ: begin
                mul_a = d_reg[2];
                mul_b = dt_eff;
            end
            OP_SQX: begin
                diff2 = ext(pa_reg[0]) - ext(pb_reg[0]);
                mul_a = diff2[W-1:0];
                mul_b = diff2[W-1:0];
            end
            OP_SQY: begin
                diff2 = ext(pa_reg[1]) - ext(pb_reg[1]);
                mul_a = diff2[W-1:0];
                mul_b = diff2[W-1:0];
            end
            OP_SQZ: begin
                diff2 = ext(pa_reg[2]) - ext(pb_reg[2]);
                mul_a = diff2[W-1:0];
                mul_b = diff2[W-1:0];
            end
            default: begin
            end
        endcase
    end

    // A difference must stay within the symmetric range, else the distance is void.
    assign diff_bad = (diff2 > WMAX2) || (diff2 < -WMAX2);

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        tsel_next     = tsel_reg;
        kind_next     = kind_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        d_next        = d_reg;
        tmp_next      = tmp_reg;
        sum_next      = sum_reg;
        sep_next      = sep_reg;
        cnt_next      = cnt_reg;
        peak_next     = peak_reg;
        peak_pos_next = peak_pos_reg;
        flag_next     = flag_reg;
        mul_start     = 1'b0;
        sqrt_start    = 1'b0;
        post_sum      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_data.kind;
                    sum_next  = '0;
                    tsel_next = 1'b0;
                    if (s_data.kind == KIND_START) begin
                        pa_next[0] = s_data.start_x_a;
                        pa_next[1] = s_data.start_y_a;
                        pa_next[2] = s_data.start_z_a;
                        pb_next[0] = s_data.start_x_b;
                        pb_next[1] = s_data.start_y_b;
                        pb_next[2] = s_data.start_z_b;
                        cnt_next   = '0;
                        flag_next  = 1'b0;
                        op_next    = OP_SQX;
                    end else begin
                        if (cnt_reg != '1) begin
                            cnt_next = cnt_reg + STEP_BITS'(1);
                        end
                        op_next = OP_DX;
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if ((op_reg == OP_SQX || op_reg == OP_SQY || op_reg == OP_SQZ) && diff_bad) begin
                    flag_next  = 1'b1;
                    sep_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    if (op_reg == OP_DX || op_reg == OP_DY) begin
                        flag_next = flag_reg | ovf_w(pre_sum);
                    end
                    mul_start  = 1'b1;
                    state_next = ST_MULW;
                end
            end
            ST_MULW: begin
                if (mul_done) begin
                    state_next = ST_ISSUE;
                    op_next    = op_reg + 4'd1;
                    case (op_reg)
                        OP_DX: begin
                            d_next[0] = q;
                            flag_next = flag_reg | q_ovf;
                        end
                        OP_DY: begin
                            post_sum  = ext(q) - ext(cy);
                            d_next[1] = sat_w(post_sum);
                            flag_next = flag_reg | q_ovf | ovf_w(post_sum);
                        end
                        OP_PXY: begin
                            tmp_next  = q;
                            flag_next = flag_reg | q_ovf;
                        end
                        OP_DZ: begin
                            post_sum  = ext(tmp_reg) - ext(q);
                            d_next[2] = sat_w(post_sum);
                            flag_next = flag_reg | q_ovf | ovf_w(post_sum);
                        end
                        OP_NX: begin
                            post_sum  = ext(cx) + ext(q);
                            d_next[0] = sat_w(post_sum);
                            flag_next = flag_reg | q_ovf | ovf_w(post_sum);
                        end
                        OP_NY: begin
                            post_sum  = ext(cy) + ext(q);
                            d_next[1] = sat_w(post_sum);
                            flag_next = flag_reg | q_ovf | ovf_w(post_sum);
                        end
                        OP_NZ: begin
                            // Commit the new point of this trajectory.
                            post_sum  = ext(cz) + ext(q);
                            flag_next = flag_reg | q_ovf | ovf_w(post_sum);
                            if (tsel_reg) begin
                                pb_next[0] = d_reg[0];
                                pb_next[1] = d_reg[1];
                                pb_next[2] = sat_w(post_sum);
                                op_next    = OP_SQX;
                            end else begin
                                pa_next[0] = d_reg[0];
                                pa_next[1] = d_reg[1];
                                pa_next[2] = sat_w(post_sum);
                                tsel_next  = 1'b1;
                                op_next    = OP_DX;
                            end
                        end
                        OP_SQX, OP_SQY: begin
                            sum_next = sum_reg + mul_p;
                        end
                        OP_SQZ: begin
                            sum_next   = sum_reg + mul_p;
                            sqrt_start = 1'b1;
                            state_next = ST_SQRTW;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SQRTW: begin
                if (sqrt_done) begin
                    flag_next  = flag_reg | root_big;
                    sep_next   = (flag_reg || root_big) ? '0 : sqrt_root[PW-1:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (kind_reg == KIND_START) begin
                        peak_next     = sep_reg;
                        peak_pos_next = '0;
                    end else if (sep_reg > peak_reg) begin
                        peak_next     = sep_reg;
                        peak_pos_next = cnt_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_DX;
            tsel_reg     <= 1'b0;
            kind_reg     <= KIND_START;
            pa_reg       <= '{default: '0};
            pb_reg       <= '{default: '0};
            cnt_reg      <= '0;
            peak_reg     <= '0;
            peak_pos_reg <= '0;
            flag_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            tsel_reg     <= tsel_next;
            kind_reg     <= kind_next;
            pa_reg       <= pa_next;
            pb_reg       <= pb_next;
            cnt_reg      <= cnt_next;
            peak_reg     <= peak_next;
            peak_pos_reg <= peak_pos_next;
            flag_reg     <= flag_next;
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        d_reg   <= d_next;
        tmp_reg <= tmp_next;
        sum_reg <= sum_next;
        sep_reg <= sep_next;
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg.step_index      <= cnt_reg;
            m_data_reg.pos_x_a         <= pa_reg[0];
            m_data_reg.pos_y_a         <= pa_reg[1];
            m_data_reg.pos_z_a         <= pa_reg[2];
            m_data_reg.pos_x_b         <= pb_reg[0];
            m_data_reg.pos_y_b         <= pb_reg[1];
            m_data_reg.pos_z_b         <= pb_reg[2];
            m_data_reg.separation      <= sep_reg;
            m_data_reg.peak_separation <= peak_next;
            m_data_reg.peak_step       <= peak_pos_next;
            m_data_reg.overflowed      <= flag_reg;
        end
    end

    tled_mul #(
        .WIDTH (W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    tled_sqrt #(
        .WIDTH (W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_next),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A flagged result always reports a zero distance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.overflowed && (m_data.separation != '0)))
        else $error("separation reported while overflow flag is set");

    // The peak can never fall below the distance reported with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.peak_separation >= m_data.separation))
        else $error("peak separation below current separation");

    // The peak was seen at or before the current step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.peak_step <= m_data.step_index))
        else $error("peak step lies after the current step");

    // The multiplier is only started while no square root is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> (state_reg == ST_ISSUE) && !sqrt_start)
        else $error("multiplier started outside issue");

endmodule
